>>> hw/rtl/vn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;

   // Smoothed lattice values: 16 hashes in (-2^30, 2^30], so 36 bits signed
   localparam int SMOOTH_W = 36;
   // Register stages inside one octave lane: 4 hash, 1 smooth, 2 blend
   localparam int LANE_LAT = 7;

   typedef logic signed [SMOOTH_W-1:0] smooth_type;

   typedef enum logic [0:0] {
      REG_PERSISTENCE = 1'b0,
      REG_OCTAVES     = 1'b1
   } csr_reg_type;

   localparam logic [31:0] HASH_MUL_Y = 32'd57;
   localparam logic [31:0] HASH_MUL_A = 32'd15731;
   localparam logic [31:0] HASH_ADD_A = 32'd789221;
   localparam logic [31:0] HASH_ADD   = 32'd1376312589;
   localparam logic signed [31:0] HASH_ONE = 32'sh4000_0000;

   localparam logic [16:0] ONE_W   = 17'd65536;
   localparam logic [16:0] AMP_ONE = 17'd65536;

   localparam longint unsigned PI_Q24  = 64'd52707179;
   localparam longint unsigned ONE_Q24 = 64'd16777216;
   localparam int TAYLOR_TERMS = 14;
   localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
      '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
        64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756};

   // Cosine blend weight (1 - cos)/2 in Q1.16, Taylor series in Q24.
   // Only ever called with constant arguments to build a ROM.
   function automatic logic [16:0] cos_weight(input int k, input int bits);
      longint unsigned a;
      longint unsigned a2;
      longint unsigned term;
      longint unsigned e;
      longint c;
      longint w;
      a    = (PI_Q24 * longint'(k)) >> bits;
      a2   = (a * a) >> 24;
      term = ONE_Q24;
      c    = longint'(ONE_Q24);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         term = (term * a2) / TAYLOR_DIV[n-1];
         if ((n & 1) == 1) begin
            c = c - longint'(term);
         end else begin
            c = c + longint'(term);
         end
      end
      w = longint'(ONE_Q24) - c;
      if (w < 0) begin
         w = 0;
      end
      e = (longint'(w) * 64'd65536 + ONE_Q24) >> 25;
      if (e > 64'd65536) begin
         e = 64'd65536;
      end
      return 17'(e);
   endfunction

   // floor((a*(1-w) + b*w) / 2^16)
   function automatic smooth_type blend(input smooth_type a, input smooth_type b,
                                        input logic [16:0] w);
      logic signed [54:0] pa;
      logic signed [54:0] pb;
      logic signed [54:0] s;
      pa = 55'(a) * 55'($signed({1'b0, ONE_W - w}));
      pb = 55'(b) * 55'($signed({1'b0, w}));
      s  = pa + pb;
      return SMOOTH_W'(s >>> 16);
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/vn_hash.sv
`timescale 1ns / 1ps
`default_nettype none
module vn_hash import vn_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [31:0]        pt_x,
   input  wire logic [31:0]        pt_y,
   output logic signed [31:0]      hash_value
);

   logic [31:0] sum_w;
   logic [31:0] n_in;
   logic [31:0] q_w;
   logic [31:0] n1_ff;
   logic [31:0] n2_ff;
   logic [31:0] n3_ff;
   logic [31:0] sq_ff;
   logic [31:0] m_ff;
   logic signed [31:0] h_ff;

   assign sum_w = pt_x + pt_y * HASH_MUL_Y;
   assign n_in  = (sum_w << 13) ^ sum_w;
   assign q_w   = n3_ff * m_ff + HASH_ADD;

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff <= n_in;
         sq_ff <= n1_ff * n1_ff;
         n2_ff <= n1_ff;
         m_ff  <= sq_ff * HASH_MUL_A + HASH_ADD_A;
         n3_ff <= n2_ff;
         h_ff  <= HASH_ONE - $signed({1'b0, q_w[30:0]});
      end
   end

   assign hash_value = h_ff;

endmodule
`default_nettype wire

>>> hw/rtl/vn_octave.sv
`timescale 1ns / 1ps
`default_nettype none
module vn_octave import vn_pkg::*; #(
   parameter int LANE           = 0,
   parameter int COS_TABLE_BITS = 8
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [31:0] x_coord,
   input  wire logic signed [31:0] y_coord,
   output smooth_type              octave_noise
);

   localparam int COS_N = 1 << COS_TABLE_BITS;

   logic [63:0] sx_w;
   logic [63:0] sy_w;
   logic [31:0] ix_w;
   logic [31:0] iy_w;
   logic [COS_TABLE_BITS-1:0] fx_idx;
   logic [COS_TABLE_BITS-1:0] fy_idx;
   logic [16:0] cos_rom [COS_N];
   logic [16:0] wx_ff [5];
   logic [16:0] wy_ff [5];
   logic [16:0] wy6_ff;
   logic signed [31:0] hash_w [4][4];
   smooth_type sm_in [4];
   smooth_type sm_ff [4];
   smooth_type bx_ff [2];
   smooth_type r_ff;

   assign sx_w   = {{32{x_coord[31]}}, x_coord} << LANE;
   assign sy_w   = {{32{y_coord[31]}}, y_coord} << LANE;
   assign ix_w   = sx_w[47:16];
   assign iy_w   = sy_w[47:16];
   assign fx_idx = sx_w[15 -: COS_TABLE_BITS];
   assign fy_idx = sy_w[15 -: COS_TABLE_BITS];

   for (genvar k = 0; k < COS_N; k++) begin : g_rom
      assign cos_rom[k] = cos_weight(k, COS_TABLE_BITS);
   end

   // 4x4 lattice around the cell, offsets -1..+2 on each axis
   for (genvar gy = 0; gy < 4; gy++) begin : g_row
      for (genvar gx = 0; gx < 4; gx++) begin : g_col
         vn_hash u_hash (
            .clock      (clock),
            .en         (en),
            .pt_x       (ix_w + 32'(gx) - 32'd1),
            .pt_y       (iy_w + 32'(gy) - 32'd1),
            .hash_value (hash_w[gy][gx])
         );
      end
   end

   // centre x4, sides x2, diagonals x1
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sm_in[c] = '0;
         for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
               sm_in[c] = sm_in[c] +
                  (SMOOTH_W'(hash_w[(c >> 1) + dy][(c & 1) + dx])
                   <<< ((dx == 1 ? 1 : 0) + (dy == 1 ? 1 : 0)));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff[0] <= cos_rom[fx_idx];
         wy_ff[0] <= cos_rom[fy_idx];
         for (int k = 1; k < 5; k++) begin
            wx_ff[k] <= wx_ff[k-1];
            wy_ff[k] <= wy_ff[k-1];
         end
         sm_ff    <= sm_in;
         bx_ff[0] <= blend(sm_ff[0], sm_ff[1], wx_ff[4]);
         bx_ff[1] <= blend(sm_ff[2], sm_ff[3], wx_ff[4]);
         wy6_ff   <= wy_ff[4];
         r_ff     <= blend(bx_ff[0], bx_ff[1], wy6_ff);
      end
   end

   assign octave_noise = r_ff;

endmodule
`default_nettype wire

>>> hw/rtl/value_noise_2d_octaves.sv
`timescale 1ns / 1ps
`default_nettype none
// Fractal 2D value noise: one sample accepted per clock while the output is not
// stalled, one result per sample, in order. The pipeline is an input register,
// seven stages of the per-octave lanes (four for the lattice hash multipliers,
// one smoothing, two cosine blends), one accumulate stage per octave and the
// output register. All octaves have their own lane, so throughput does not
// depend on octave_count. A stalled output holds the whole pipeline. Write
// persistence and octave_count only while no sample is in flight.
module value_noise_2d_octaves import vn_pkg::*; #(
   parameter int MAX_OCTAVES    = 8,
   parameter int COS_TABLE_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // x_coord[31:0], y_coord[63:32]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // noise_value[23:0]
   output logic             rsp_tuser,   // saturated
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);

   localparam int CNT_W   = $clog2(MAX_OCTAVES + 1);
   localparam int TOTAL_W = 59 + $clog2(MAX_OCTAVES);
   localparam int RW      = TOTAL_W - 34;

   logic                 en;
   logic [15:0]          persist_ff;
   logic [3:0]           octaves_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic signed [31:0]   x_ff;
   logic signed [31:0]   y_ff;
   logic [CNT_W-1:0]     cnt0_ff;
   logic                 v0_ff;
   logic                 ld_v_ff [LANE_LAT];
   logic [CNT_W-1:0]     ld_cnt_ff [LANE_LAT];
   smooth_type           r_lane [MAX_OCTAVES];
   logic                 acc_v_ff [MAX_OCTAVES];
   logic [CNT_W-1:0]     acc_cnt_ff [MAX_OCTAVES];
   logic signed [TOTAL_W-1:0] acc_total_ff [MAX_OCTAVES];
   logic [16:0]          acc_amp_ff [MAX_OCTAVES];
   smooth_type           acc_r_ff [MAX_OCTAVES][MAX_OCTAVES];
   logic signed [RW-1:0] res_w;
   logic                 fits_w;
   logic [23:0]          noise_in;
   logic                 rsp_v_ff;
   logic [23:0]          rsp_noise_ff;
   logic                 rsp_sat_ff;

   assign en         = !rsp_v_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         persist_ff <= 16'd32768;
         octaves_ff <= 4'd4;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_PERSISTENCE: persist_ff <= csr_wdata;
            REG_OCTAVES:     octaves_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (octaves_ff == '0) begin
         cnt_in = CNT_W'(1);
      end else if (32'(octaves_ff) > MAX_OCTAVES) begin
         cnt_in = CNT_W'(MAX_OCTAVES);
      end else begin
         cnt_in = CNT_W'(octaves_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         for (int k = 0; k < LANE_LAT; k++) begin
            ld_v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v0_ff      <= req_tvalid;
         ld_v_ff[0] <= v0_ff;
         for (int k = 1; k < LANE_LAT; k++) begin
            ld_v_ff[k] <= ld_v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff         <= $signed(req_tdata[31:0]);
         y_ff         <= $signed(req_tdata[63:32]);
         cnt0_ff      <= cnt_in;
         ld_cnt_ff[0] <= cnt0_ff;
         for (int k = 1; k < LANE_LAT; k++) begin
            ld_cnt_ff[k] <= ld_cnt_ff[k-1];
         end
      end
   end

   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
      vn_octave #(
         .LANE           (i),
         .COS_TABLE_BITS (COS_TABLE_BITS)
      ) u_octave (
         .clock        (clock),
         .en           (en),
         .x_coord      (x_ff),
         .y_coord      (y_ff),
         .octave_noise (r_lane[i])
      );
   end

   // one stage per octave: add noise*amp while below the octave count, step amp by persistence
   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_acc
      smooth_type                r_src [MAX_OCTAVES];
      logic                      v_src;
      logic [CNT_W-1:0]          c_src;
      logic signed [TOTAL_W-1:0] t_src;
      logic [16:0]               a_src;
      logic signed [53:0]        prod_w;

      if (k == 0) begin : g_first
         assign v_src = ld_v_ff[LANE_LAT-1];
         assign c_src = ld_cnt_ff[LANE_LAT-1];
         assign t_src = '0;
         assign a_src = AMP_ONE;
         assign r_src = r_lane;
      end else begin : g_next
         assign v_src = acc_v_ff[k-1];
         assign c_src = acc_cnt_ff[k-1];
         assign t_src = acc_total_ff[k-1];
         assign a_src = acc_amp_ff[k-1];
         assign r_src = acc_r_ff[k-1];
      end

      assign prod_w = 54'(r_src[k]) * 54'($signed({1'b0, a_src}));

      always_ff @(posedge clock) begin
         if (reset) begin
            acc_v_ff[k] <= 1'b0;
         end else if (en) begin
            acc_v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            acc_cnt_ff[k]   <= c_src;
            acc_total_ff[k] <= (CNT_W'(k) < c_src) ? t_src + TOTAL_W'(prod_w) : t_src;
            acc_amp_ff[k]   <= 17'((34'(a_src) * 34'(persist_ff)) >> 16);
            acc_r_ff[k]     <= r_src;
         end
      end
   end

   assign res_w    = RW'(acc_total_ff[MAX_OCTAVES-1] >>> 34);
   assign fits_w   = (&res_w[RW-1:23]) || !(|res_w[RW-1:23]);
   assign noise_in = fits_w ? res_w[23:0] : (res_w[RW-1] ? 24'h800000 : 24'h7fffff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         rsp_v_ff <= acc_v_ff[MAX_OCTAVES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_noise_ff <= noise_in;
         rsp_sat_ff   <= !fits_w;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_noise_ff;
   assign rsp_tuser  = rsp_sat_ff;

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 24'h7fffff || rsp_tdata == 24'h800000)
      else $error("saturated result not at a range limit");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      acc_v_ff[0] |-> acc_cnt_ff[0] != '0 && 32'(acc_cnt_ff[0]) <= MAX_OCTAVES)
      else $error("octave count out of range in accumulator");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(acc_total_ff[MAX_OCTAVES-1]) && $stable(acc_v_ff[0]))
      else $error("pipeline moved while output stalled");

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
   import vn_pkg::*;

   localparam int OCT_MAX   = 8;
   localparam int COS_BITS  = 8;
   localparam int COS_ENTRIES = 1 << COS_BITS;
   localparam int PIPE_LAT  = OCT_MAX + 9;
   localparam int N_RANDOM  = 1250;
   localparam longint CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   longint cycles = 0;
   bit     quiet_tail = 1'b0;
   bit     long_hold = 1'b0;

   value_noise_2d_octaves #(.MAX_OCTAVES(OCT_MAX), .COS_TABLE_BITS(COS_BITS)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic signed [23:0] noise;
      logic               sat;
   } noise_res_t;

   class noise_scoreboard;
      noise_res_t  pending[$];
      int unsigned mismatches = 0;
      logic [15:0] persist = 16'd32768;
      logic [3:0]  octaves = 4'd4;
      logic [16:0] cos_rom [COS_ENTRIES];

      function new();
         longint unsigned a, a2, term, e;
         longint c, w;
         for (int k = 0; k < COS_ENTRIES; k++) begin
            a = (64'd52707179 * longint'(k)) >> COS_BITS;
            a2 = (a * a) >> 24;
            term = 64'd16777216;
            c = 64'sd16777216;
            for (int n = 1; n <= 14; n++) begin
               term = (term * a2) / longint'((2 * n - 1) * (2 * n));
               if (n % 2 == 1) c = c - longint'(term);
               else c = c + longint'(term);
            end
            w = 64'sd16777216 - c;
            if (w < 0) w = 0;
            e = (longint'(w) * 64'd65536 + 64'd16777216) >> 25;
            if (e > 64'd65536) e = 64'd65536;
            cos_rom[k] = 17'(e);
         end
      endfunction

      function longint hash_val(logic [31:0] x, logic [31:0] y);
         logic [31:0] n, m;
         n = x + y * 32'd57;
         n = (n << 13) ^ n;
         m = n * n * 32'd15731 + 32'd789221;
         m = (n * m + 32'd1376312589) & 32'h7fffffff;
         return (64'sd1 << 30) - longint'({32'd0, m});
      endfunction

      function longint smoothed(logic [31:0] x, logic [31:0] y);
         longint corners, sides;
         corners = hash_val(x - 1, y - 1) + hash_val(x + 1, y - 1)
                 + hash_val(x - 1, y + 1) + hash_val(x + 1, y + 1);
         sides = hash_val(x - 1, y) + hash_val(x + 1, y)
               + hash_val(x, y - 1) + hash_val(x, y + 1);
         return corners + 2 * sides + 4 * hash_val(x, y);
      endfunction

      function longint mix(longint a, longint b, logic [16:0] w);
         return (a * longint'(65536 - w) + b * longint'(w)) >>> 16;
      endfunction

      function void note_sample(logic [63:0] d);
         logic signed [63:0] xs, ys, sx, sy;
         logic [31:0] ix, iy;
         logic [16:0] wx, wy;
         logic [31:0] amp;
         logic signed [127:0] total, res;
         int cnt;
         noise_res_t r;
         xs = 64'(signed'(d[31:0]));
         ys = 64'(signed'(d[63:32]));
         cnt = octaves == 0 ? 1 : (octaves > OCT_MAX ? OCT_MAX : octaves);
         amp = 32'd65536;
         total = '0;
         for (int i = 0; i < cnt; i++) begin
            sx = xs << i;
            sy = ys << i;
            ix = sx[47:16];
            iy = sy[47:16];
            wx = cos_rom[sx[15:16-COS_BITS]];
            wy = cos_rom[sy[15:16-COS_BITS]];
            total += 128'(signed'(mix(mix(smoothed(ix, iy), smoothed(ix + 1, iy), wx),
                                      mix(smoothed(ix, iy + 1), smoothed(ix + 1, iy + 1), wx),
                                      wy))) * signed'({96'd0, amp});
            amp = 32'((64'(amp) * persist) >> 16);
         end
         res = total >>> 34;
         r.sat = 1'b0;
         if (res > 8388607) begin
            res = 8388607;
            r.sat = 1'b1;
         end else if (res < -8388608) begin
            res = -8388608;
            r.sat = 1'b1;
         end
         r.noise = res[23:0];
         pending.push_back(r);
      endfunction

      function void check_result(logic [23:0] noise, logic sat);
         noise_res_t e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result noise=%h sat=%b", noise, sat);
            return;
         end
         e = pending.pop_front();
         if (e.noise !== noise || e.sat !== sat) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected noise=%h sat=%b, got noise=%h sat=%b",
                        e.noise, e.sat, noise, sat);
         end
      endfunction
   endclass

   noise_scoreboard sb = new();

   // monitor, sampled at the edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_tvalid && req_tready) sb.note_sample(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // receiver: random stall bursts, a long hold when asked
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            for (int i = 0; i < 200; i++) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_sample(logic [31:0] x, logic [31:0] y);
      int gap;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_PERSISTENCE) sb.persist = val;
      else sb.octaves = val[3:0];
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
         2: return {16'($urandom_range(0, 40)), 16'($urandom())};
         default: return 32'(signed'($urandom_range(0, 200)) - 100) <<< 16 | 16'($urandom());
      endcase
   endfunction

   initial begin
      logic [31:0] edge_vals [6];
      logic [15:0] pers_set [5];
      logic [3:0]  oct_set [6];
      edge_vals = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0000ffff, 32'h00010000};
      pers_set = '{16'd0, 16'd65535, 16'd32768, 16'd1, 16'd49152};
      oct_set = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd9, 4'd5};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes at reset settings
      foreach (edge_vals[i]) send_sample(edge_vals[i], edge_vals[5 - i]);
      send_sample(32'h7fffffff, 32'h7fffffff);
      send_sample(32'h80000000, 32'h80000000);
      drain();
      // octave count zero and above the maximum, large sums
      write_reg(REG_OCTAVES, 16'hffff);
      write_reg(REG_PERSISTENCE, 16'hffff);
      for (int i = 0; i < 8; i++) send_sample($urandom(), $urandom());
      drain();
      write_reg(REG_OCTAVES, 16'd0);
      for (int i = 0; i < 4; i++) send_sample(edge_vals[i], edge_vals[i + 1]);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_PERSISTENCE, pers_set[ph % 5]);
         write_reg(REG_OCTAVES, {12'd0, oct_set[ph]});
         if (ph == 2) long_hold = 1'b1;
         if (ph == 5) quiet_tail = 1'b1;
         for (int i = 0; i < N_RANDOM / 6; i++) send_sample(rand_coord(), rand_coord());
         drain();
      end
      if (sb.mismatches == 0 && sb.pending.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end
endmodule
